/* hdl/smes_pkg.sv */
package smes_pkg;

    // Default sizing of the store.
    localparam int MAX_DIM_DEF     = 64;
    localparam int CAPACITY_DEF    = 1024;
    localparam int VALUE_WIDTH_DEF = 32;

    // Configuration register widths, indexes and reset values.
    localparam int CFG_W          = 7;
    localparam int ROW_COUNT_RST  = 64;
    localparam int COL_COUNT_RST  = 64;
    localparam logic CFG_ROW_COUNT    = 1'b0;
    localparam logic CFG_COLUMN_COUNT = 1'b1;

    // Width of the reported nonzero count.
    localparam int NZ_W = 10;

    // Action codes.
    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_DONE     = 3'd0,
        ST_REPLACED = 3'd1,
        ST_INSERTED = 3'd2,
        ST_FULL     = 3'd3,
        ST_RANGE    = 3'd4
    } status_t;

    // Handshake and status between the engine and the top level.
    typedef struct packed {
        logic    idle;
        logic    done;
        status_t status;
    } eng_ctl_t;

    // Engine sequencer states.
    typedef enum logic [3:0] {
        S_SWEEP,
        S_IDLE,
        S_DISPATCH,
        S_DIAG,
        S_PTR_LO,
        S_PTR_HI,
        S_PTR_USED,
        S_SEARCH,
        S_PROBE,
        S_CHECK,
        S_DECIDE,
        S_SHIFT,
        S_PLACE,
        S_BUMP,
        S_FINISH
    } eng_state_t;

endpackage

/* hdl/smes_engine.sv */
module smes_engine #(
    parameter int MAX_DIM     = smes_pkg::MAX_DIM_DEF,
    parameter int CAPACITY    = smes_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = smes_pkg::VALUE_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [1:0]                      action,
    input  logic [$clog2(MAX_DIM)-1:0]      row,
    input  logic [$clog2(MAX_DIM)-1:0]      col,
    input  logic [VALUE_WIDTH-1:0]          write_value,
    input  logic [$clog2(MAX_DIM+1)-1:0]    rows,
    input  logic [$clog2(MAX_DIM+1)-1:0]    cols,
    input  logic                            slot_free,
    output smes_pkg::eng_ctl_t              ctl,
    output logic [VALUE_WIDTH-1:0]          rd_value,
    output logic [smes_pkg::NZ_W-1:0]       nz_count
);
    import smes_pkg::*;

    localparam int ROW_W     = $clog2(MAX_DIM);
    localparam int DIMC_W    = $clog2(MAX_DIM + 1);
    localparam int KP_W      = DIMC_W + 1;
    localparam int ADDR_W    = $clog2(CAPACITY);
    localparam int PTR_W     = $clog2(CAPACITY + 1);
    localparam int ROW_LIMIT = (MAX_DIM < CAPACITY) ? MAX_DIM : CAPACITY - 1;
    localparam int RESET_ROWS = (ROW_COUNT_RST < 1) ? 1 :
                                ((ROW_COUNT_RST > ROW_LIMIT) ? ROW_LIMIT : ROW_COUNT_RST);
    localparam logic [PTR_W-1:0] CAP_P = PTR_W'(CAPACITY);

    // Storage.
    logic [PTR_W-1:0]       ptr_mem [0:MAX_DIM];
    logic [ROW_W-1:0]       col_mem [0:CAPACITY-1];
    logic [VALUE_WIDTH-1:0] val_mem [0:CAPACITY-1];

    logic [PTR_W-1:0]       ptr_rd_reg;
    logic [ROW_W-1:0]       col_rd_reg;
    logic [VALUE_WIDTH-1:0] val_rd_reg;

    logic [DIMC_W-1:0]      ptr_raddr;
    logic                   ptr_we;
    logic [DIMC_W-1:0]      ptr_waddr;
    logic [PTR_W-1:0]       ptr_wdata;
    logic [ADDR_W-1:0]      mem_raddr;
    logic [ADDR_W-1:0]      mem_waddr;
    logic                   col_we;
    logic [ROW_W-1:0]       col_wdata;
    logic                   val_we;
    logic [VALUE_WIDTH-1:0] val_wdata;

    // Sequencer registers.
    eng_state_t             state_reg, state_next;
    logic [1:0]             act_reg, act_next;
    logic [ROW_W-1:0]       row_reg, row_next;
    logic [ROW_W-1:0]       col_reg, col_next;
    logic [VALUE_WIDTH-1:0] wv_reg, wv_next;
    logic [PTR_W-1:0]       lo_reg, lo_next;
    logic [PTR_W-1:0]       hi_reg, hi_next;
    logic [PTR_W-1:0]       used_reg, used_next;
    logic [PTR_W-1:0]       a_reg, a_next;
    logic [PTR_W-1:0]       b_reg, b_next;
    logic [PTR_W-1:0]       mid_reg, mid_next;
    logic [PTR_W-1:0]       k_reg, k_next;
    logic [KP_W-1:0]        kp_reg, kp_next;
    logic                   pend_reg, pend_next;
    logic [ADDR_W-1:0]      waddr_reg, waddr_next;
    logic [DIMC_W-1:0]      pwaddr_reg, pwaddr_next;
    logic [KP_W-1:0]        lim_reg, lim_next;
    logic [KP_W-1:0]        vlim_reg, vlim_next;
    logic [PTR_W-1:0]       pv_reg, pv_next;
    logic                   clr_reg, clr_next;
    logic                   found_reg, found_next;
    status_t                status_reg, status_next;
    logic [VALUE_WIDTH-1:0] res_value_reg, res_value_next;
    logic [NZ_W-1:0]        nz_reg, nz_next;

    logic [PTR_W-1:0]       base;
    logic                   done;

    function automatic logic [PTR_W-1:0] clamp_ptr(input logic [PTR_W-1:0] v,
                                                   input logic [PTR_W-1:0] lo,
                                                   input logic [PTR_W-1:0] hi);
        if (v < lo) begin
            return lo;
        end
        if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    assign base = PTR_W'(rows) + PTR_W'(1);

    // Row pointer memory, one read and one write port.
    always_ff @(posedge clk)
    begin
        if (ptr_we)
        begin
            ptr_mem[ptr_waddr] <= ptr_wdata;
        end
        ptr_rd_reg <= ptr_mem[ptr_raddr];
    end

    // Column index and value memories share their read address.
    always_ff @(posedge clk)
    begin
        if (col_we)
        begin
            col_mem[mem_waddr] <= col_wdata;
        end
        if (val_we)
        begin
            val_mem[mem_waddr] <= val_wdata;
        end
        col_rd_reg <= col_mem[mem_raddr];
        val_rd_reg <= val_mem[mem_raddr];
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SWEEP;
            act_reg       <= ACT_READ;
            row_reg       <= '0;
            col_reg       <= '0;
            wv_reg        <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            used_reg      <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            mid_reg       <= '0;
            k_reg         <= '0;
            kp_reg        <= '0;
            pend_reg      <= 1'b0;
            waddr_reg     <= '0;
            pwaddr_reg    <= '0;
            lim_reg       <= KP_W'(MAX_DIM);
            vlim_reg      <= KP_W'(ROW_LIMIT);
            pv_reg        <= PTR_W'(RESET_ROWS + 1);
            clr_reg       <= 1'b0;
            found_reg     <= 1'b0;
            status_reg    <= ST_DONE;
            res_value_reg <= '0;
            nz_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            act_reg       <= act_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            wv_reg        <= wv_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            used_reg      <= used_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            mid_reg       <= mid_next;
            k_reg         <= k_next;
            kp_reg        <= kp_next;
            pend_reg      <= pend_next;
            waddr_reg     <= waddr_next;
            pwaddr_reg    <= pwaddr_next;
            lim_reg       <= lim_next;
            vlim_reg      <= vlim_next;
            pv_reg        <= pv_next;
            clr_reg       <= clr_next;
            found_reg     <= found_next;
            status_reg    <= status_next;
            res_value_reg <= res_value_next;
            nz_reg        <= nz_next;
        end
    end

    // Sequencer: next state, memory accesses and results.
    always_comb
    begin
        state_next     = state_reg;
        act_next       = act_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        wv_next        = wv_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        used_next      = used_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        mid_next       = mid_reg;
        k_next         = k_reg;
        kp_next        = kp_reg;
        pend_next      = pend_reg;
        waddr_next     = waddr_reg;
        pwaddr_next    = pwaddr_reg;
        lim_next       = lim_reg;
        vlim_next      = vlim_reg;
        pv_next        = pv_reg;
        clr_next       = clr_reg;
        found_next     = found_reg;
        status_next    = status_reg;
        res_value_next = res_value_reg;
        nz_next        = nz_reg;

        ptr_raddr = '0;
        ptr_we    = 1'b0;
        ptr_waddr = pwaddr_reg;
        ptr_wdata = ptr_rd_reg + PTR_W'(1);
        mem_raddr = '0;
        mem_waddr = waddr_reg;
        col_we    = 1'b0;
        col_wdata = col_rd_reg;
        val_we    = 1'b0;
        val_wdata = val_rd_reg;
        done      = 1'b0;

        case (state_reg)
            // Sweep over the row pointers and the diagonal, at reset or on a clear.
            S_SWEEP:
            begin
                ptr_we    = 1'b1;
                ptr_waddr = kp_reg[DIMC_W-1:0];
                ptr_wdata = pv_reg;
                if (kp_reg <= vlim_reg)
                begin
                    val_we    = 1'b1;
                    mem_waddr = ADDR_W'(kp_reg);
                    val_wdata = '0;
                end
                kp_next = kp_reg + KP_W'(1);
                if (kp_reg == lim_reg)
                begin
                    state_next = clr_reg ? S_FINISH : S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    act_next   = action;
                    row_next   = row;
                    col_next   = col;
                    wv_next    = write_value;
                    state_next = S_DISPATCH;
                end
            end

            // Sort the item by kind and bounds.
            S_DISPATCH:
            begin
                res_value_next = '0;
                status_next    = ST_DONE;
                if (act_reg == ACT_CLEAR)
                begin
                    kp_next    = '0;
                    lim_next   = KP_W'(rows);
                    vlim_next  = KP_W'(rows);
                    pv_next    = base;
                    clr_next   = 1'b1;
                    nz_next    = '0;
                    state_next = S_SWEEP;
                end
                else if ((act_reg != ACT_READ && act_reg != ACT_WRITE) ||
                         DIMC_W'(row_reg) >= rows || DIMC_W'(col_reg) >= cols)
                begin
                    status_next = ST_RANGE;
                    state_next  = S_FINISH;
                end
                else if (row_reg == col_reg)
                begin
                    if (act_reg == ACT_READ)
                    begin
                        mem_raddr  = ADDR_W'(row_reg);
                        state_next = S_DIAG;
                    end
                    else
                    begin
                        val_we      = 1'b1;
                        mem_waddr   = ADDR_W'(row_reg);
                        val_wdata   = wv_reg;
                        status_next = ST_REPLACED;
                        state_next  = S_FINISH;
                    end
                end
                else
                begin
                    ptr_raddr  = DIMC_W'(row_reg);
                    state_next = S_PTR_LO;
                end
            end

            S_DIAG:
            begin
                res_value_next = val_rd_reg;
                state_next     = S_FINISH;
            end

            // Fetch and clamp the row bounds and the end of the used area.
            S_PTR_LO:
            begin
                lo_next    = clamp_ptr(ptr_rd_reg, base, CAP_P);
                ptr_raddr  = DIMC_W'(row_reg) + DIMC_W'(1);
                state_next = S_PTR_HI;
            end

            S_PTR_HI:
            begin
                hi_next    = clamp_ptr(ptr_rd_reg, lo_reg, CAP_P);
                ptr_raddr  = rows;
                state_next = S_PTR_USED;
            end

            S_PTR_USED:
            begin
                used_next  = clamp_ptr(ptr_rd_reg, hi_reg, CAP_P);
                a_next     = lo_reg;
                b_next     = hi_reg;
                state_next = S_SEARCH;
            end

            // Binary search over the row's column indices.
            S_SEARCH:
            begin
                if (a_reg < b_reg)
                begin
                    mid_next   = a_reg + ((b_reg - a_reg) >> 1);
                    mem_raddr  = ADDR_W'(a_reg + ((b_reg - a_reg) >> 1));
                    state_next = S_PROBE;
                end
                else if (a_reg < hi_reg)
                begin
                    mem_raddr  = ADDR_W'(a_reg);
                    state_next = S_CHECK;
                end
                else
                begin
                    found_next = 1'b0;
                    state_next = S_DECIDE;
                end
            end

            S_PROBE:
            begin
                if (col_rd_reg < col_reg)
                begin
                    a_next = mid_reg + PTR_W'(1);
                end
                else
                begin
                    b_next = mid_reg;
                end
                state_next = S_SEARCH;
            end

            S_CHECK:
            begin
                found_next = (col_rd_reg == col_reg);
                if (act_reg == ACT_READ && col_rd_reg == col_reg)
                begin
                    res_value_next = val_rd_reg;
                end
                state_next = S_DECIDE;
            end

            S_DECIDE:
            begin
                if (act_reg == ACT_READ)
                begin
                    status_next = ST_DONE;
                    state_next  = S_FINISH;
                end
                else if (found_reg)
                begin
                    val_we      = 1'b1;
                    mem_waddr   = ADDR_W'(a_reg);
                    val_wdata   = wv_reg;
                    status_next = ST_REPLACED;
                    state_next  = S_FINISH;
                end
                else if (used_reg >= CAP_P)
                begin
                    status_next = ST_FULL;
                    state_next  = S_FINISH;
                end
                else
                begin
                    k_next     = used_reg;
                    pend_next  = 1'b0;
                    state_next = S_SHIFT;
                end
            end

            // Move entries up by one, one entry a cycle: read below, write the last read.
            S_SHIFT:
            begin
                if (pend_reg)
                begin
                    col_we = 1'b1;
                    val_we = 1'b1;
                end
                if (k_reg > a_reg)
                begin
                    mem_raddr  = ADDR_W'(k_reg - PTR_W'(1));
                    waddr_next = ADDR_W'(k_reg);
                    pend_next  = 1'b1;
                    k_next     = k_reg - PTR_W'(1);
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = S_PLACE;
                end
            end

            S_PLACE:
            begin
                col_we     = 1'b1;
                val_we     = 1'b1;
                mem_waddr  = ADDR_W'(a_reg);
                col_wdata  = col_reg;
                val_wdata  = wv_reg;
                kp_next    = KP_W'(row_reg) + KP_W'(1);
                pend_next  = 1'b0;
                state_next = S_BUMP;
            end

            // Increment the row pointers after the inserted row.
            S_BUMP:
            begin
                if (pend_reg)
                begin
                    ptr_we = 1'b1;
                end
                if (kp_reg <= KP_W'(rows))
                begin
                    ptr_raddr   = kp_reg[DIMC_W-1:0];
                    pwaddr_next = kp_reg[DIMC_W-1:0];
                    pend_next   = 1'b1;
                    kp_next     = kp_reg + KP_W'(1);
                end
                else
                begin
                    pend_next   = 1'b0;
                    nz_next     = nz_reg + NZ_W'(1);
                    status_next = ST_INSERTED;
                    state_next  = S_FINISH;
                end
            end

            // Hand the result over once the output register is free.
            S_FINISH:
            begin
                clr_next = 1'b0;
                if (slot_free)
                begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign ctl.idle   = (state_reg == S_IDLE);
    assign ctl.done   = done;
    assign ctl.status = status_reg;
    assign rd_value   = res_value_reg;
    assign nz_count   = nz_reg;

endmodule

/* hdl/sparse_matrix_element_store.sv */
// Sparse matrix element store in compressed-row form, with the diagonal kept apart.
// Items arrive on the item channel (item_valid/item_ready) carrying action, row,
// col and write_value; each item gives exactly one beat on the result channel
// (result_valid/result_ready) with read_value, status and nonzero_count.
// Configuration beats (cfg_valid/cfg_ready, cfg_index, cfg_data) set row_count
// and column_count; they are always taken and should arrive only while idle.
// One item is worked on at a time by a sequencer around the row pointer, column
// index and value memories. An off-diagonal read or write looks up the column by
// binary search; an insert also moves each later entry up by one and increments
// each following row pointer; a clear sweeps the row pointers and the diagonal.
// Each memory has a single read port, which every search step and every moved
// entry uses. After reset the block sweeps the row pointers and the diagonal
// with item_ready low. A finished result sits in the output register while the
// next item is taken; if the receiver stalls, that next item completes its work
// and then waits until the result register is free.
module sparse_matrix_element_store #(
    parameter int MAX_DIM     = smes_pkg::MAX_DIM_DEF,
    parameter int CAPACITY    = smes_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = smes_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  logic [1:0]                    action,
    input  logic [$clog2(MAX_DIM)-1:0]    row,
    input  logic [$clog2(MAX_DIM)-1:0]    col,
    input  logic [VALUE_WIDTH-1:0]        write_value,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic [VALUE_WIDTH-1:0]        read_value,
    output logic [2:0]                    status,
    output logic [smes_pkg::NZ_W-1:0]     nonzero_count,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [smes_pkg::CFG_W-1:0]    cfg_data
);
    import smes_pkg::*;

    localparam int DIMC_W    = $clog2(MAX_DIM + 1);
    localparam int CMP_W     = CFG_W + DIMC_W;
    localparam int ROW_LIMIT = (MAX_DIM < CAPACITY) ? MAX_DIM : CAPACITY - 1;

    logic [CFG_W-1:0]       row_count_reg;
    logic [CFG_W-1:0]       column_count_reg;
    logic [DIMC_W-1:0]      rows_use;
    logic [DIMC_W-1:0]      cols_use;

    logic                   result_valid_reg;
    logic [VALUE_WIDTH-1:0] read_value_reg;
    status_t                status_reg;
    logic [NZ_W-1:0]        nonzero_count_reg;

    eng_ctl_t               ctl;
    logic [VALUE_WIDTH-1:0] eng_value;
    logic [NZ_W-1:0]        eng_count;
    logic                   slot_free;
    logic                   start;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= CFG_W'(ROW_COUNT_RST);
            column_count_reg <= CFG_W'(COL_COUNT_RST);
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_ROW_COUNT)
            begin
                row_count_reg <= cfg_data;
            end
            else
            begin
                column_count_reg <= cfg_data;
            end
        end
    end

    // Dimensions in use, clamped to what the store can hold.
    always_comb
    begin
        if (row_count_reg == '0)
        begin
            rows_use = DIMC_W'(1);
        end
        else if (CMP_W'(row_count_reg) > CMP_W'(ROW_LIMIT))
        begin
            rows_use = DIMC_W'(ROW_LIMIT);
        end
        else
        begin
            rows_use = DIMC_W'(row_count_reg);
        end

        if (column_count_reg == '0)
        begin
            cols_use = DIMC_W'(1);
        end
        else if (CMP_W'(column_count_reg) > CMP_W'(MAX_DIM))
        begin
            cols_use = DIMC_W'(MAX_DIM);
        end
        else
        begin
            cols_use = DIMC_W'(column_count_reg);
        end
    end

    assign item_ready = ctl.idle;
    assign start      = item_valid && ctl.idle;
    assign slot_free  = !result_valid_reg || result_ready;

    smes_engine #(
        .MAX_DIM     (MAX_DIM),
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .action      (action),
        .row         (row),
        .col         (col),
        .write_value (write_value),
        .rows        (rows_use),
        .cols        (cols_use),
        .slot_free   (slot_free),
        .ctl         (ctl),
        .rd_value    (eng_value),
        .nz_count    (eng_count)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (ctl.done)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.done)
        begin
            read_value_reg    <= eng_value;
            status_reg        <= ctl.status;
            nonzero_count_reg <= eng_count;
        end
    end

    assign result_valid  = result_valid_reg;
    assign read_value    = read_value_reg;
    assign status        = status_reg;
    assign nonzero_count = nonzero_count_reg;

endmodule
